/* design/sem_pkg.sv */
// ---------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the 3x3 Sobel edge magnitude unit.
// ---------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int FIFO_DEPTH     = 8;
    localparam int EDGE_MAX       = 255;

    typedef logic [PIX_W-1:0] t_pix;

    // window[row][col], row 0 is the oldest line, col 0 the leftmost column
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } t_req;

    typedef struct packed {
        logic valid;
        logic last;
    } t_kern_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             last_of_frame;
    } t_result;

endpackage

/* design/sem_line_ram.sv */
// ---------------------------------------------------------------------------
// sem_line_ram
// One line store: single write port, single registered read port.
// Read-first on a same-address collision.
// ---------------------------------------------------------------------------
module sem_line_ram
    import sem_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_pix                     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_pix                     o_rdata
);

    t_pix r_mem [DEPTH];
    t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/sem_kernel.sv */
// ---------------------------------------------------------------------------
// sem_kernel
// Sobel x/y gradients of a masked 3x3 window, then saturated |gx|+|gy|.
// ---------------------------------------------------------------------------
module sem_kernel
    import sem_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_window   i_win,
    input  t_kern_ctl i_ctl,
    output t_kern_ctl o_ctl,
    output t_pix      o_edge
);

    localparam int SUM_W = PIX_W + 2;
    localparam int GRD_W = SUM_W + 1;

    logic [SUM_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [GRD_W-1:0] n_gx, n_gy;
    logic signed [GRD_W-1:0] r_gx, r_gy;
    t_kern_ctl r_ctl;
    logic [SUM_W-1:0] abs_gx, abs_gy;
    logic [GRD_W-1:0] mag;

    always_comb begin
        gx_pos = SUM_W'(i_win[0][2]) + SUM_W'({i_win[1][2], 1'b0}) + SUM_W'(i_win[2][2]);
        gx_neg = SUM_W'(i_win[0][0]) + SUM_W'({i_win[1][0], 1'b0}) + SUM_W'(i_win[2][0]);
        gy_pos = SUM_W'(i_win[0][0]) + SUM_W'({i_win[0][1], 1'b0}) + SUM_W'(i_win[0][2]);
        gy_neg = SUM_W'(i_win[2][0]) + SUM_W'({i_win[2][1], 1'b0}) + SUM_W'(i_win[2][2]);
        n_gx   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        n_gy   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gx <= n_gx;
        r_gy <= n_gy;
    end

    always_comb begin
        abs_gx = r_gx[GRD_W-1] ? SUM_W'(-r_gx) : SUM_W'(r_gx);
        abs_gy = r_gy[GRD_W-1] ? SUM_W'(-r_gy) : SUM_W'(r_gy);
        mag    = GRD_W'(abs_gx) + GRD_W'(abs_gy);
        o_edge = (mag > GRD_W'(EDGE_MAX)) ? PIX_W'(EDGE_MAX) : mag[PIX_W-1:0];
    end

    assign o_ctl = r_ctl;

endmodule

/* design/sem_out_fifo.sv */
// ---------------------------------------------------------------------------
// sem_out_fifo
// Result queue between the kernel and the output stream.
// ---------------------------------------------------------------------------
module sem_out_fifo
    import sem_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]   r_count;
    logic            pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + NW'(i_push) - NW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < NW'(DEPTH)) || pop)
        else $error("result queue overflow");

endmodule

/* design/sobel_edge_magnitude_3x3_unit.sv */
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_3x3_unit
// Streaming 3x3 Sobel edge magnitude over raster-order grayscale pixels.
// ---------------------------------------------------------------------------
//
// Channel   | Dir | Handshake                      | Payload
// ----------+-----+--------------------------------+---------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata: pixel_value[7:0]
//           |     |                                | tuser: req_type (1 = flush)
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata: edge_value[7:0]
//           |     |                                | tlast: last_of_frame
// cfg       | in  | i_cfg_wen (no wait)            | i_cfg_index, i_cfg_wdata
//
// One request per clock is taken while s_axis_tready is high. A result
// appears on m_axis once the request that completes its neighborhood is
// taken and has passed the line store read, window shift and mask,
// gradient register, then the result queue.
// The two line stores are single-port-write RAMs with one read a cycle; a
// read that meets the write of the previous request at the same column is
// forwarded.
// s_axis_tready falls only when the result queue plus the results in flight
// reach the queue depth, so a stalled m_axis side never loses a result.
// Reset (synchronous, active low) clears counters, window and queue; the
// line stores are not cleared, since unwritten entries only feed masked
// window positions. Width and height apply through the registered
// effective sizes and area after a write, which also restarts the frame.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_unit
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel_value
    input  logic                 s_axis_tuser,   // [0] req_type
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [7:0] edge_value
    output logic                 m_axis_tlast    // last_of_frame
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 2);
    localparam int IDX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int AREA_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CRW    = $clog2(FIFO_DEPTH + 1);

    // -----------------------------------------------------------------------
    // Configuration and effective frame size
    // -----------------------------------------------------------------------
    logic [CFG_W-1:0]  r_frame_width, r_frame_height;
    logic [WW-1:0]     r_w_eff;
    logic [RW-1:0]     r_h_eff;
    logic [AREA_W-1:0] r_area;
    int unsigned       w_sat, h_sat;

    always_comb begin
        w_sat = 32'(r_frame_width);
        if (w_sat < 1) w_sat = 1;
        if (w_sat > MAX_WIDTH) w_sat = MAX_WIDTH;
        h_sat = 32'(r_frame_height);
        if (h_sat < 1) h_sat = 1;
        if (h_sat > MAX_HEIGHT) h_sat = MAX_HEIGHT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(640);
            r_frame_height <= CFG_W'(480);
        end else if (i_cfg_wen) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // derived sizes are registered from the configuration registers; the user
    // must write only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_w_eff <= WW'(w_sat);
        r_h_eff <= RW'(h_sat);
        r_area  <= AREA_W'(r_w_eff * r_h_eff);
    end

    // -----------------------------------------------------------------------
    // Request decode against the raster counters
    // -----------------------------------------------------------------------
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [IDX_W-1:0]  r_idx;
    logic [CRW-1:0]    r_credit;

    logic              take, is_flush, draining, req_ok;
    logic              col_is0, have_old, have_new, have, last;
    logic              m_top, m_bot, m_left;
    logic [WW-1:0]     col_inc;
    logic              wrap;
    logic [AREA_W-1:0] idx_inc;
    logic              pop;

    assign s_axis_tready = (r_credit < CRW'(FIFO_DEPTH));
    assign take          = s_axis_tvalid && s_axis_tready;
    assign is_flush      = (t_req'(s_axis_tuser) == REQ_FLUSH);
    assign draining      = (r_row >= r_h_eff);
    // drop pixels while draining and flushes while pixels are still due
    assign req_ok        = take && (is_flush == draining);

    always_comb begin
        col_is0  = (r_col == '0);
        // column 0 finishes the last pixel of two rows up
        have_old = col_is0 && (r_row >= RW'(2));
        have_new = !col_is0 && (r_row != '0);
        have     = have_old || have_new;
        if (have_old) begin
            m_top  = (r_row == RW'(2));
            m_bot  = (r_row > r_h_eff);
            m_left = (r_w_eff == WW'(1));
        end else begin
            m_top  = (r_row == RW'(1));
            m_bot  = (r_row >= r_h_eff);
            m_left = (r_col == CW'(1));
        end
        col_inc = WW'(r_col) + 1'b1;
        wrap    = (col_inc >= r_w_eff);
        idx_inc = AREA_W'(r_idx) + 1'b1;
        last    = have && (idx_inc == r_area);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (i_cfg_wen) begin
            // restart the frame, keep window and line stores
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (req_ok) begin
            if (last) begin
                r_col <= '0;
                r_row <= '0;
                r_idx <= '0;
            end else begin
                if (wrap) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= col_inc[CW-1:0];
                end
                if (have) begin
                    r_idx <= idx_inc[IDX_W-1:0];
                end
            end
        end
    end

    // reserve a queue slot for every result put in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CRW'(req_ok && have) - CRW'(pop);
        end
    end

    // -----------------------------------------------------------------------
    // Stage A: line store read data, forwarding, write back
    // -----------------------------------------------------------------------
    logic          r_a_valid;
    logic          r_a_is_pix, r_a_have, r_a_old, r_a_last;
    logic          r_a_mtop, r_a_mbot, r_a_mleft;
    logic [CW-1:0] r_a_col;
    t_pix          r_a_pix;
    logic          r_a_fwd;
    t_pix          r_a_fwd_top, r_a_fwd_mid;
    t_pix          top_rd, mid_rd, a_top, a_mid;
    logic          ram_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= req_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_is_pix  <= !is_flush;
        r_a_pix     <= is_flush ? '0 : s_axis_tdata;
        r_a_col     <= r_col;
        r_a_have    <= have;
        r_a_old     <= have_old;
        r_a_last    <= last;
        r_a_mtop    <= m_top;
        r_a_mbot    <= m_bot;
        r_a_mleft   <= m_left;
        // the write under way lands after this read: carry its data along
        r_a_fwd     <= ram_we && (r_a_col == r_col);
        r_a_fwd_top <= a_mid;
        r_a_fwd_mid <= r_a_pix;
    end

    assign a_top  = r_a_fwd ? r_a_fwd_top : top_rd;
    assign a_mid  = r_a_fwd ? r_a_fwd_mid : mid_rd;
    assign ram_we = r_a_valid && r_a_is_pix;

    sem_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_two_above (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_a_col),
        .i_wdata (a_mid),
        .i_raddr (r_col),
        .o_rdata (top_rd)
    );

    sem_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_above (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_a_col),
        .i_wdata (r_a_pix),
        .i_raddr (r_col),
        .o_rdata (mid_rd)
    );

    // -----------------------------------------------------------------------
    // Window shift and neighborhood mask
    // -----------------------------------------------------------------------
    t_window   r_win;
    t_window   nb;
    t_window   r_b_win;
    t_kern_ctl r_b_ctl;
    t_pix      new_col [3];

    assign new_col[0] = a_top;
    assign new_col[1] = a_mid;
    assign new_col[2] = r_a_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_a_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
                r_win[i][2] <= new_col[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nb[i][0] = r_win[i][1];
            nb[i][1] = r_win[i][2];
            // column 0 result: the centre sat at the right frame edge
            nb[i][2] = r_a_old ? '0 : new_col[i];
            if (r_a_mleft) nb[i][0] = '0;
        end
        if (r_a_mtop) nb[0] = '0;
        if (r_a_mbot) nb[2] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else begin
            r_b_ctl.valid <= r_a_valid && r_a_have;
            r_b_ctl.last  <= r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_win <= nb;
    end

    // -----------------------------------------------------------------------
    // Gradients and result queue
    // -----------------------------------------------------------------------
    t_kern_ctl k_ctl;
    t_pix      k_edge;
    t_result   push_data, head;

    sem_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (r_b_win),
        .i_ctl   (r_b_ctl),
        .o_ctl   (k_ctl),
        .o_edge  (k_edge)
    );

    assign push_data.edge_value    = k_edge;
    assign push_data.last_of_frame = k_ctl.last;

    sem_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (k_ctl.valid),
        .i_data  (push_data),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (head)
    );

    assign pop          = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = head.edge_value;
    assign m_axis_tlast = head.last_of_frame;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRW'(FIFO_DEPTH))
        else $error("result credit above queue depth");

    a_credit_covers_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_credit != '0))
        else $error("result shown without a reserved slot");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_ok && last && !i_cfg_wen) |=> (r_col == '0) && (r_row == '0) && (r_idx == '0))
        else $error("frame did not restart after its last result");

endmodule
